// File: design/slefr_pkg.sv
// Shared types and constants for the start/length/end byte frame receiver.
`timescale 1ns / 1ps

package slefr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned RegIdxW = 2;

  localparam logic [ByteW-1:0] StartValueRst = 8'h02;
  localparam logic [ByteW-1:0] EndValueRst   = 8'h03;
  localparam logic [ByteW-1:0] MaxLengthRst  = 8'd250;

  // Register index, taken from paddr[3:2]
  typedef enum logic [RegIdxW-1:0] {
    REG_START_VALUE = 2'd0,
    REG_END_VALUE   = 2'd1,
    REG_MAX_LENGTH  = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_END  = 2'd3
  } rx_phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2,
    KIND_RSVD = 2'd3
  } out_kind_e;

  // One result transaction as held in the output register
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] frame_length;
    logic [ByteW-1:0] data;
    logic             last;
  } result_t;

endpackage

// File: design/stx_len_etx_frame_receiver_unit.sv
// Top level of the start/length/end byte frame receiver.
`timescale 1ns / 1ps

//  Channel   | Direction | Handshake                     | Payload
//  ----------+-----------+-------------------------------+-------------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | tdata[7:0] rx_byte
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata[7:0] out_byte,
//            |           |                               | tdata[15:8] frame_length,
//            |           |                               | tuser[1:0] out_kind, tlast last
//  apb       | in        | psel/penable, pready tied 1   | 0x0 start_value, 0x4 end_value,
//            |           |                               | 0x8 max_length (8 bits each)
//
// Throughput is one byte per cycle while m_axis is not stalled: a byte sits in
// the input register, the phase logic decides it and writes the output register.
// An s_axis byte is registered in the input register, its result in the output register.
// s_axis_tready falls only when the input register holds a byte whose result
// cannot enter the output register because m_axis is stalled.
// Reset clears phase, counters, valid flags and loads the register defaults.
// Start, length and rejected-length bytes produce no output transaction.

module stx_len_etx_frame_receiver_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // byte stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [slefr_pkg::ByteW-1:0]    s_axis_tdata,   // [7:0] rx_byte
  // result stream out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [2*slefr_pkg::ByteW-1:0]  m_axis_tdata,   // [7:0] out_byte, [15:8] frame_length
  output logic [slefr_pkg::KindW-1:0]    m_axis_tuser,   // [1:0] out_kind
  output logic                           m_axis_tlast,   // last
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [slefr_pkg::ApbAddrW-1:0] paddr,
  input  logic [slefr_pkg::ApbDataW-1:0] pwdata,
  output logic [slefr_pkg::ApbDataW-1:0] prdata,
  output logic                           pready
);

  localparam int unsigned BW = slefr_pkg::ByteW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [BW-1:0]       start_value_q, end_value_q, max_length_q;
  logic                cfg_wr;
  slefr_pkg::reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = slefr_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_value_q <= slefr_pkg::StartValueRst;
      end_value_q   <= slefr_pkg::EndValueRst;
      max_length_q  <= slefr_pkg::MaxLengthRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        slefr_pkg::REG_START_VALUE: start_value_q <= pwdata[BW-1:0];
        slefr_pkg::REG_END_VALUE:   end_value_q   <= pwdata[BW-1:0];
        slefr_pkg::REG_MAX_LENGTH:  max_length_q  <= pwdata[BW-1:0];
        default: ;  // unmapped: write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      slefr_pkg::REG_START_VALUE: prdata = {{(slefr_pkg::ApbDataW-BW){1'b0}}, start_value_q};
      slefr_pkg::REG_END_VALUE:   prdata = {{(slefr_pkg::ApbDataW-BW){1'b0}}, end_value_q};
      slefr_pkg::REG_MAX_LENGTH:  prdata = {{(slefr_pkg::ApbDataW-BW){1'b0}}, max_length_q};
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic          in_valid_q;
  logic [BW-1:0] in_byte_q;
  logic          proc_fire;   // byte in input register is decided this cycle
  logic          out_free;    // output register can take a new result
  logic          res_valid;   // decided byte yields an output transaction

  assign out_free      = ~m_axis_tvalid | m_axis_tready;
  assign proc_fire     = in_valid_q & (~res_valid | out_free);
  assign s_axis_tready = ~in_valid_q | proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame phase machine
  // ---------------------------------------------------------------------------
  slefr_pkg::rx_phase_e phase_q, phase_d;
  logic [BW-1:0]        bytes_left_q, bytes_left_d;
  logic [BW-1:0]        cur_len_q, cur_len_d;
  logic [BW-1:0]        left_dec;
  logic                 len_bad;

  assign len_bad  = (in_byte_q == '0) || (in_byte_q > max_length_q);
  // guard keeps the count from wrapping; in payload it is never zero
  assign left_dec = bytes_left_q - BW'(bytes_left_q != '0);

  // next state
  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    cur_len_d    = cur_len_q;
    unique case (phase_q)
      slefr_pkg::PH_HUNT: begin
        if (in_byte_q == start_value_q) phase_d = slefr_pkg::PH_LEN;
      end
      slefr_pkg::PH_LEN: begin
        if (len_bad) begin
          phase_d = slefr_pkg::PH_HUNT;   // rejected length, not rechecked as start
        end else begin
          phase_d      = slefr_pkg::PH_DATA;
          bytes_left_d = in_byte_q;
          cur_len_d    = in_byte_q;
        end
      end
      slefr_pkg::PH_DATA: begin
        bytes_left_d = left_dec;
        if (left_dec == '0) phase_d = slefr_pkg::PH_END;
      end
      slefr_pkg::PH_END: begin
        phase_d = slefr_pkg::PH_HUNT;
      end
      default: phase_d = slefr_pkg::PH_HUNT;
    endcase
  end

  // outputs
  slefr_pkg::result_t res;

  always_comb begin
    res_valid        = 1'b0;
    res.kind         = slefr_pkg::KIND_DATA;
    res.data         = in_byte_q;
    res.frame_length = cur_len_q;
    res.last         = 1'b0;
    unique case (phase_q)
      slefr_pkg::PH_DATA: begin
        res_valid = in_valid_q;
      end
      slefr_pkg::PH_END: begin
        res_valid = in_valid_q;
        res.kind  = (in_byte_q == end_value_q) ? slefr_pkg::KIND_GOOD : slefr_pkg::KIND_BAD;
        res.last  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= slefr_pkg::PH_HUNT;
      bytes_left_q <= '0;
      cur_len_q    <= '0;
    end else if (proc_fire) begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      cur_len_q    <= cur_len_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic               out_valid_q;
  slefr_pkg::result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc_fire & res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && proc_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.frame_length, out_q.data};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // payload phase always has bytes still to come
  a_data_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == slefr_pkg::PH_DATA |-> bytes_left_q != '0)
    else $error("payload phase with zero bytes left");

  // end byte always returns to hunting and posts a closing result
  a_end_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && phase_q == slefr_pkg::PH_END |=>
      phase_q == slefr_pkg::PH_HUNT && out_valid_q && out_q.last)
    else $error("end byte did not close the frame");

  // a rejected length byte never enters the payload phase
  a_bad_len_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && phase_q == slefr_pkg::PH_LEN && len_bad |=> phase_q == slefr_pkg::PH_HUNT)
    else $error("bad length accepted");

  // a stalled result is never overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q && $stable(out_q))
    else $error("stalled result lost");

endmodule
